// ===== design/lfpse_pkg.sv =====
`timescale 1ns / 1ps

package lfpse_pkg;

  // widths and reset values
  localparam int unsigned PosW             = 6;
  localparam int unsigned MaxFrameBytesDef = 22;
  localparam int unsigned CfgW             = 15;
  localparam int unsigned SymW             = 16;
  localparam int unsigned ByteW            = 8;
  localparam int unsigned IdxW             = 3;

  localparam logic [CfgW-1:0] BitPeriodRst = 15'd100;
  localparam logic [CfgW-1:0] BitHighRst   = 15'd50;
  localparam logic [SymW-1:0] DummyPeriod  = 16'd99;

  // last symbol index of each segment
  localparam logic [IdxW-1:0] PlainLastIdx   = 3'd7;
  localparam logic [IdxW-1:0] PatternLastIdx = 3'd4;
  localparam logic [IdxW-1:0] DummyLastIdx   = 3'd1;

  // configuration register indexes
  typedef enum logic {
    REG_BIT_PERIOD    = 1'b0,
    REG_BIT_HIGH_TIME = 1'b1
  } reg_idx_e;

  // what one byte turns into
  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_PLAIN,
    MODE_PATTERN,
    MODE_PLAIN_PAT
  } job_mode_e;

  // symbol segment inside a job
  typedef enum logic [1:0] {
    SEG_PLAIN,
    SEG_PATTERN,
    SEG_DUMMY
  } seg_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    job_mode_e        mode;
    logic             dummies;
    logic             dropped;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // pattern symbol lengths in bit times
  function automatic logic [1:0] pattern_mult(logic [IdxW-1:0] idx);
    logic [1:0] m;
    case (idx)
      3'd0:    m = 2'd3;
      3'd1:    m = 2'd1;
      3'd2:    m = 2'd2;
      3'd3:    m = 2'd2;
      default: m = 2'd1;
    endcase
    return m;
  endfunction

  // small constant multiple, modulo 2^16
  function automatic logic [SymW-1:0] scale(logic [CfgW-1:0] v, logic [1:0] m);
    logic [SymW-1:0] r;
    case (m)
      2'd2:    r = {v, 1'b0};
      2'd3:    r = {v, 1'b0} + {1'b0, v};
      default: r = {1'b0, v};
    endcase
    return r;
  endfunction

endpackage

// ===== design/lfpse_front.sv =====
`timescale 1ns / 1ps

module lfpse_front #(
  parameter int unsigned MaxFrameBytes = lfpse_pkg::MaxFrameBytesDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic [lfpse_pkg::ByteW-1:0]      data_byte_i,
  input  logic                             last_byte_i,
  output logic                             in_ready_o,
  input  lfpse_pkg::q_stat_t               q_stat_i,
  output logic                             push_o,
  output lfpse_pkg::job_t                  job_o
);

  localparam logic [lfpse_pkg::PosW-1:0] MaxPos = lfpse_pkg::PosW'(MaxFrameBytes);

  logic [lfpse_pkg::PosW-1:0] pos_q, pos_d;
  logic                       drop_q, drop_d;
  logic                       accept;
  logic                       over;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign over       = (pos_q >= MaxPos);

  // classify the word by its frame position
  always_comb begin
    job_o.data    = data_byte_i;
    job_o.dummies = last_byte_i;
    job_o.dropped = drop_q || over;
    if (over) begin
      job_o.mode = lfpse_pkg::MODE_NONE;
    end else if (pos_q == '0) begin
      job_o.mode = last_byte_i ? lfpse_pkg::MODE_PLAIN_PAT : lfpse_pkg::MODE_PLAIN;
    end else if (pos_q == lfpse_pkg::PosW'(1)) begin
      job_o.mode = lfpse_pkg::MODE_PATTERN;
    end else begin
      job_o.mode = lfpse_pkg::MODE_PLAIN;
    end
  end

  // a dropped word that does not end the frame makes no job
  assign push_o = accept && (!over || last_byte_i);

  // frame position tracking
  always_comb begin
    pos_d  = pos_q;
    drop_d = drop_q;
    if (accept) begin
      if (last_byte_i) begin
        pos_d  = '0;
        drop_d = 1'b0;
      end else if (over) begin
        pos_d  = MaxPos;
        drop_d = 1'b1;
      end else begin
        pos_d = pos_q + lfpse_pkg::PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      drop_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      drop_q <= drop_d;
    end
  end

endmodule

// ===== design/lfpse_queue.sv =====
`timescale 1ns / 1ps

module lfpse_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lfpse_pkg::job_t    job_i,
  input  logic               pop_i,
  output lfpse_pkg::q_stat_t stat_o,
  output lfpse_pkg::job_t    head_o
);

  lfpse_pkg::job_t entry_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign head_o       = entry_q[rd_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
    end
  end

  // job storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= job_i;
    end
  end

endmodule

// ===== design/lfpse_back.sv =====
`timescale 1ns / 1ps

module lfpse_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lfpse_pkg::CfgW-1:0]     bit_period_i,
  input  logic [lfpse_pkg::CfgW-1:0]     bit_high_time_i,
  input  lfpse_pkg::q_stat_t             q_stat_i,
  input  lfpse_pkg::job_t                head_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lfpse_pkg::SymW-1:0]     symbol_period_o,
  output logic [lfpse_pkg::SymW-1:0]     symbol_high_o,
  output logic                           invert_level_o,
  output logic                           overflow_o,
  output logic                           end_of_run_o
);

  logic                        active_q;
  lfpse_pkg::seg_e             seg_q, seg_d, cur_seg;
  logic [lfpse_pkg::IdxW-1:0]  idx_q, idx_d, cur_idx;
  logic                        adv;
  logic                        last_sym;
  logic [1:0]                  mult;
  logic [lfpse_pkg::SymW-1:0]  per_d, high_d;
  logic                        inv_d, ovf_d;

  logic                        out_valid_q;
  logic [lfpse_pkg::SymW-1:0]  per_q, high_q;
  logic                        inv_q, ovf_q, eor_q;

  // cursor: saved position, or the start of the head job
  always_comb begin
    cur_idx = active_q ? idx_q : '0;
    cur_seg = seg_q;
    if (!active_q) begin
      case (head_i.mode)
        lfpse_pkg::MODE_PATTERN: cur_seg = lfpse_pkg::SEG_PATTERN;
        lfpse_pkg::MODE_NONE:    cur_seg = lfpse_pkg::SEG_DUMMY;
        default:                 cur_seg = lfpse_pkg::SEG_PLAIN;
      endcase
    end
  end

  assign adv   = !q_stat_i.empty && (!out_valid_q || out_ready_i);
  assign pop_o = adv && last_sym;

  // symbol for the current cursor
  always_comb begin
    mult     = 2'd1;
    inv_d    = 1'b0;
    ovf_d    = 1'b0;
    last_sym = 1'b0;
    seg_d    = cur_seg;
    idx_d    = cur_idx + lfpse_pkg::IdxW'(1);
    unique case (cur_seg)
      lfpse_pkg::SEG_PLAIN: begin
        inv_d = head_i.data[cur_idx];
        if (cur_idx == lfpse_pkg::PlainLastIdx) begin
          idx_d = '0;
          if (head_i.mode == lfpse_pkg::MODE_PLAIN_PAT) begin
            seg_d = lfpse_pkg::SEG_PATTERN;
          end else if (head_i.dummies) begin
            seg_d = lfpse_pkg::SEG_DUMMY;
          end else begin
            last_sym = 1'b1;
          end
        end
      end
      lfpse_pkg::SEG_PATTERN: begin
        mult  = lfpse_pkg::pattern_mult(cur_idx);
        inv_d = (head_i.mode == lfpse_pkg::MODE_PATTERN) && head_i.data[cur_idx];
        if (cur_idx == lfpse_pkg::PatternLastIdx) begin
          idx_d = '0;
          if (head_i.dummies) begin
            seg_d = lfpse_pkg::SEG_DUMMY;
          end else begin
            last_sym = 1'b1;
          end
        end
      end
      lfpse_pkg::SEG_DUMMY: begin
        ovf_d = head_i.dropped;
        if (cur_idx == lfpse_pkg::DummyLastIdx) begin
          last_sym = 1'b1;
        end
      end
      default: begin
        last_sym = 1'b1;
      end
    endcase
  end

  // timing values, modulo 2^16
  always_comb begin
    if (cur_seg == lfpse_pkg::SEG_DUMMY) begin
      per_d  = lfpse_pkg::DummyPeriod;
      high_d = '0;
    end else begin
      per_d  = lfpse_pkg::scale(bit_period_i, mult) - lfpse_pkg::SymW'(1);
      high_d = lfpse_pkg::scale(bit_high_time_i, mult);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      seg_q       <= lfpse_pkg::SEG_PLAIN;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      active_q    <= !last_sym;
      seg_q       <= seg_d;
      idx_q       <= idx_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      per_q  <= per_d;
      high_q <= high_d;
      inv_q  <= inv_d;
      ovf_q  <= ovf_d;
      eor_q  <= last_sym;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign symbol_period_o = per_q;
  assign symbol_high_o   = high_q;
  assign invert_level_o  = inv_q;
  assign overflow_o      = ovf_q;
  assign end_of_run_o    = eor_q;

endmodule

// ===== design/lf_frame_pwm_symbol_encoder_core.sv =====
`timescale 1ns / 1ps

// Frame PWM symbol encoder: each accepted byte word inside the frame limit becomes a run of
// PWM symbols, one per data bit LSB first (period minus one, high time, polarity), with the
// pattern symbols for the second byte and two dummy symbols after the last byte. The back
// end emits one symbol per clock unless out_ready_i stalls it, and it holds its output word
// while stalled. A two-entry job queue between the classifier and the symbol generator lets
// input arrive while symbols are still being taken. An accepted byte is stored in the job
// queue, and its first symbol is then registered in the output word register.
// Write bit_period and bit_high_time only while the block is idle.
module lf_frame_pwm_symbol_encoder_core #(
  parameter int unsigned MaxFrameBytes = lfpse_pkg::MaxFrameBytesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [lfpse_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lfpse_pkg::ByteW-1:0]    data_byte_i,
  input  logic                           last_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lfpse_pkg::SymW-1:0]     symbol_period_o,
  output logic [lfpse_pkg::SymW-1:0]     symbol_high_o,
  output logic                           invert_level_o,
  output logic                           overflow_o,
  output logic                           end_of_run_o
);

  logic [lfpse_pkg::CfgW-1:0] bit_period_q, bit_high_q;
  lfpse_pkg::q_stat_t         q_stat;
  lfpse_pkg::job_t            push_job, head_job;
  logic                       push, pop;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q <= lfpse_pkg::BitPeriodRst;
      bit_high_q   <= lfpse_pkg::BitHighRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lfpse_pkg::reg_idx_e'(cfg_index_i))
        lfpse_pkg::REG_BIT_PERIOD:    bit_period_q <= cfg_data_i;
        lfpse_pkg::REG_BIT_HIGH_TIME: bit_high_q   <= cfg_data_i;
        default:                      bit_period_q <= bit_period_q;
      endcase
    end
  end

  // classifier
  lfpse_front #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .in_ready_o  (in_ready_o),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .job_o       (push_job)
  );

  // job queue
  lfpse_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .stat_o (q_stat),
    .head_o (head_job)
  );

  // symbol generator
  lfpse_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .bit_period_i    (bit_period_q),
    .bit_high_time_i (bit_high_q),
    .q_stat_i        (q_stat),
    .head_i          (head_job),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .symbol_period_o (symbol_period_o),
    .symbol_high_o   (symbol_high_o),
    .invert_level_o  (invert_level_o),
    .overflow_o      (overflow_o),
    .end_of_run_o    (end_of_run_o)
  );

endmodule

// ===== design/lfpse_checker.sv =====
`timescale 1ns / 1ps

module lfpse_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [lfpse_pkg::SymW-1:0] symbol_period_o,
  input logic [lfpse_pkg::SymW-1:0] symbol_high_o,
  input logic                       invert_level_o,
  input logic                       overflow_o,
  input logic                       end_of_run_o
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(symbol_period_o)
      && $stable(symbol_high_o) && $stable(end_of_run_o))
    else $error("output word changed while stalled");

  // overflow only rides on a dummy symbol
  a_ovf_dummy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> symbol_period_o == lfpse_pkg::DummyPeriod
      && symbol_high_o == '0 && !invert_level_o)
    else $error("overflow on a non-dummy symbol");

  // a data one never carries overflow
  a_inv_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invert_level_o |-> !overflow_o)
    else $error("inverted symbol flagged overflow");

endmodule

bind lf_frame_pwm_symbol_encoder_core lfpse_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .symbol_period_o (symbol_period_o),
  .symbol_high_o   (symbol_high_o),
  .invert_level_o  (invert_level_o),
  .overflow_o      (overflow_o),
  .end_of_run_o    (end_of_run_o)
);

// ===== test/tb_lf_frame_pwm_symbol_encoder_core.sv =====
`timescale 1ns / 1ps

module tb_lf_frame_pwm_symbol_encoder_core;
  import lfpse_pkg::*;

  localparam int unsigned FrameLimit = MaxFrameBytesDef;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } byte_word_t;

  typedef struct packed {
    logic [SymW-1:0] period;
    logic [SymW-1:0] high;
    logic            invert;
    logic            overflow;
    logic            run_end;
  } symbol_t;

  // dut ports
  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic             cfg_index_i = REG_BIT_PERIOD;
  logic [CfgW-1:0]  cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [ByteW-1:0] data_byte_i = '0;
  logic             last_byte_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [SymW-1:0]  symbol_period_o;
  logic [SymW-1:0]  symbol_high_o;
  logic             invert_level_o;
  logic             overflow_o;
  logic             end_of_run_o;

  // stimulus and scoreboard
  byte_word_t  bytes_pending[$];
  symbol_t     symbols_due[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned symbols_seen = 0;
  int unsigned frames_sent = 0;
  int unsigned bytes_dropped = 0;
  int unsigned settings_used = 1;
  int unsigned mismatches = 0;
  logic        steady = 1'b0;

  // encoder state as predicted
  logic [CfgW-1:0] period_cfg = BitPeriodRst;
  logic [CfgW-1:0] high_cfg = BitHighRst;
  logic [PosW-1:0] frame_pos = '0;
  logic            frame_drop = 1'b0;

  lf_frame_pwm_symbol_encoder_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .symbol_period_o (symbol_period_o),
    .symbol_high_o   (symbol_high_o),
    .invert_level_o  (invert_level_o),
    .overflow_o      (overflow_o),
    .end_of_run_o    (end_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  // bit times of the five pattern symbols
  function automatic int unsigned pattern_span(input int unsigned slot);
    int unsigned span;
    case (slot)
      0:       span = 3;
      2, 3:    span = 2;
      default: span = 1;
    endcase
    return span;
  endfunction

  // one data symbol of the given length in bit times
  function automatic symbol_t make_symbol(input int unsigned span, input logic bit_val);
    symbol_t     s;
    logic [31:0] ticks;
    logic [31:0] active;
    ticks = period_cfg * span - 1;
    active = high_cfg * span;
    s.period = ticks[SymW-1:0];
    s.high = active[SymW-1:0];
    s.invert = bit_val;
    s.overflow = 1'b0;
    s.run_end = 1'b0;
    return s;
  endfunction

  // symbols that one accepted byte word produces
  task automatic encode_byte(input logic [ByteW-1:0] b, input logic last);
    symbol_t run[$];
    symbol_t d;
    if (frame_pos >= FrameLimit) begin
      frame_drop = 1'b1;
      frame_pos = PosW'(FrameLimit);
      bytes_dropped++;
    end else if (frame_pos == 0) begin
      for (int i = 0; i < 8; i++) run.push_back(make_symbol(1, b[i]));
      // one-byte frame: second byte reads as zero
      if (last) for (int i = 0; i < 5; i++) run.push_back(make_symbol(pattern_span(i), 1'b0));
      frame_pos = PosW'(1);
    end else if (frame_pos == 1) begin
      for (int i = 0; i < 5; i++) run.push_back(make_symbol(pattern_span(i), b[i]));
      frame_pos = PosW'(2);
    end else begin
      for (int i = 0; i < 8; i++) run.push_back(make_symbol(1, b[i]));
      frame_pos = (frame_pos + 1 > FrameLimit) ? PosW'(FrameLimit) : frame_pos + PosW'(1);
    end
    // trailing dummies close the frame
    if (last) begin
      d = '0;
      d.period = DummyPeriod;
      d.overflow = frame_drop;
      run.push_back(d);
      run.push_back(d);
      frame_pos = '0;
      frame_drop = 1'b0;
      frames_sent++;
    end
    if (run.size() > 0) run[run.size()-1].run_end = 1'b1;
    foreach (run[i]) symbols_due.push_back(run[i]);
  endtask

  // byte driver
  always @(posedge clk_i) begin : byte_driver
    byte_word_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        encode_byte(data_byte_i, last_byte_i);
        bytes_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (bytes_pending.size() > 0 && (steady || $urandom_range(0, 99) >= 9)) begin
          nxt = bytes_pending.pop_front();
          in_valid_i <= 1'b1;
          data_byte_i <= nxt.data;
          last_byte_i <= nxt.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [SymW-1:0] want,
                             input logic [SymW-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // symbol monitor
  always @(posedge clk_i) begin : symbol_monitor
    symbol_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        symbols_seen++;
        if (symbols_due.size() == 0) begin
          mismatches++;
          $display("%0t ns: symbol with none pending, expected nothing, got period %0d",
                   $time, symbol_period_o);
        end else begin
          want = symbols_due.pop_front();
          check_field("symbol_period", want.period, symbol_period_o);
          check_field("symbol_high", want.high, symbol_high_o);
          check_field("invert_level", SymW'(want.invert), SymW'(invert_level_o));
          check_field("overflow", SymW'(want.overflow), SymW'(overflow_o));
          check_field("end_of_run", SymW'(want.run_end), SymW'(end_of_run_o));
        end
      end
      out_ready_i <= steady || ($urandom_range(0, 99) >= 9);
    end
  end

  task automatic add_byte(input logic [ByteW-1:0] b, input logic last);
    byte_word_t w;
    w.data = b;
    w.last = last;
    bytes_pending.push_back(w);
    bytes_queued++;
  endtask

  // whole frames of random content, a few past the frame limit
  task automatic add_frames(input int unsigned n_bytes);
    int unsigned goal;
    int unsigned len;
    int unsigned pick;
    logic [ByteW-1:0] b;
    goal = bytes_queued + n_bytes;
    while (bytes_queued < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) len = $urandom_range(1, 4);
      else if (pick < 85) len = $urandom_range(5, FrameLimit);
      else len = $urandom_range(FrameLimit + 1, FrameLimit + 5);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 9);
        b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : ByteW'($urandom_range(0, 255));
        add_byte(b, k == len - 1);
      end
    end
  endtask

  // all words taken, all symbols back, then room for a dropped word in flight
  task automatic wait_idle();
    int unsigned spins;
    spins = 0;
    while (bytes_taken != bytes_queued) @(posedge clk_i);
    while (symbols_due.size() != 0 && spins < 20000) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_BIT_PERIOD) period_cfg = value;
    else high_cfg = value;
  endtask

  task automatic new_setting(input logic [CfgW-1:0] period, input logic [CfgW-1:0] high);
    write_reg(REG_BIT_PERIOD, period);
    write_reg(REG_BIT_HIGH_TIME, high);
    settings_used++;
  endtask

  // run limit
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: one-byte frames at the extremes, then a frame past the limit
    // whose closing word is dropped, all with reset register values
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hA5, 1'b0);
    add_byte(8'hFF, 1'b0);
    for (int i = 2; i < FrameLimit; i++) begin
      add_byte({i[3:0], ~i[3:0]}, 1'b0);
    end
    add_byte(8'h3C, 1'b1);
    wait_idle();

    // shortest bit time, no active time
    new_setting(15'd1, 15'd0);
    add_frames(70);
    wait_idle();

    // widest in-range values, no idling on either side
    new_setting(15'd21845, 15'd21845);
    @(posedge clk_i);
    steady <= 1'b1;
    add_frames(70);
    wait_idle();
    steady <= 1'b0;

    // zero period and full-scale high time wrap modulo 2^16
    new_setting(15'd0, 15'h7FFF);
    add_frames(70);
    wait_idle();

    // random in-range settings
    repeat (2) begin
      new_setting(CfgW'($urandom_range(1, 21845)), CfgW'($urandom_range(0, 21845)));
      add_frames(60);
      wait_idle();
    end

    if (symbols_due.size() != 0) begin
      mismatches++;
      $display("%0t ns: symbols never delivered, expected %0d more, got 0",
               $time, symbols_due.size());
    end
    $display("covered %0d byte words in %0d frames (%0d dropped past the limit)",
             bytes_taken, frames_sent, bytes_dropped);
    $display("checked %0d symbols under %0d register settings", symbols_seen, settings_used);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== lf_frame_pwm_symbol_encoder_core.f =====
design/lfpse_pkg.sv
design/lfpse_front.sv
design/lfpse_queue.sv
design/lfpse_back.sv
design/lf_frame_pwm_symbol_encoder_core.sv
design/lfpse_checker.sv
test/tb_lf_frame_pwm_symbol_encoder_core.sv
